// ===== hdl/aess_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aess_pkg
// Types, register indexes and reset values shared by the actuator end-stop
// sequencer modules.
// ----------------------------------------------------------------------------
package aess_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_EXTEND    = 3'd1,
    MODE_PAUSE     = 3'd2,
    MODE_RETRACT   = 3'd3,
    MODE_EXTENDED  = 3'd4,
    MODE_RETRACTED = 3'd5,
    MODE_ERROR     = 3'd6
  } mode_t;

  typedef enum logic [2:0] {
    CFG_END_BY_TIME    = 3'd0,
    CFG_MOTOR_TEST     = 3'd1,
    CFG_TRAVEL_TIME    = 3'd2,
    CFG_FAULT_TIME     = 3'd3,
    CFG_MIN_CURRENT    = 3'd4,
    CFG_LOW_COUNT_LIM  = 3'd5,
    CFG_DEBOUNCE       = 3'd6,
    CFG_REVERSE_PAUSE  = 3'd7
  } cfg_idx_t;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  localparam logic [16:0] MOTION_MAX = 17'h1FFFF;
  localparam logic [9:0]  TIMER10_MAX = 10'h3FF;
  localparam logic [3:0]  LOW_MAX = 4'hF;

  localparam logic        RST_END_BY_TIME   = 1'b0;
  localparam logic        RST_MOTOR_TEST    = 1'b1;
  localparam logic [15:0] RST_TRAVEL_TIME   = 16'd10000;
  localparam logic [16:0] RST_FAULT_TIME    = 17'd15000;
  localparam logic [11:0] RST_MIN_CURRENT   = 12'd70;
  localparam logic [3:0]  RST_LOW_COUNT_LIM = 4'd2;
  localparam logic [9:0]  RST_DEBOUNCE      = 10'd500;
  localparam logic [9:0]  RST_REVERSE_PAUSE = 10'd500;

  typedef struct packed {
    logic        end_by_time;
    logic        motor_test_at_start;
    logic [15:0] travel_time_ms;
    logic [16:0] fault_time_ms;
    logic [11:0] min_current_ma;
    logic [3:0]  low_count_limit;
    logic [9:0]  debounce_ms;
    logic [9:0]  reverse_pause_ms;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [16:0] motion_timer;
    logic [9:0]  pause_timer;
    logic [9:0]  debounce_timer;
    logic        debounce_running;
    logic        press_pending;
    logic [3:0]  low_readings;
    logic        timeout_flag;
    logic        test_pending;
  } state_t;

  typedef struct packed {
    logic        req_type;
    logic [9:0]  elapsed_ms;
    logic        button_level;
    logic [12:0] current_ma;
  } item_t;

endpackage

// ===== hdl/aess_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aess_cfg
// Configuration register file, written one register per cycle.
// ----------------------------------------------------------------------------
module aess_cfg import aess_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.end_by_time         <= RST_END_BY_TIME;
      cfg.motor_test_at_start <= RST_MOTOR_TEST;
      cfg.travel_time_ms      <= RST_TRAVEL_TIME;
      cfg.fault_time_ms       <= RST_FAULT_TIME;
      cfg.min_current_ma      <= RST_MIN_CURRENT;
      cfg.low_count_limit     <= RST_LOW_COUNT_LIM;
      cfg.debounce_ms         <= RST_DEBOUNCE;
      cfg.reverse_pause_ms    <= RST_REVERSE_PAUSE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_END_BY_TIME:   cfg.end_by_time         <= cfg_wdata[0];
        CFG_MOTOR_TEST:    cfg.motor_test_at_start <= cfg_wdata[0];
        CFG_TRAVEL_TIME:   cfg.travel_time_ms      <= cfg_wdata[15:0];
        CFG_FAULT_TIME:    cfg.fault_time_ms       <= cfg_wdata[16:0];
        CFG_MIN_CURRENT:   cfg.min_current_ma      <= cfg_wdata[11:0];
        CFG_LOW_COUNT_LIM: cfg.low_count_limit     <= cfg_wdata[3:0];
        CFG_DEBOUNCE:      cfg.debounce_ms         <= cfg_wdata[9:0];
        CFG_REVERSE_PAUSE: cfg.reverse_pause_ms    <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/aess_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aess_step
// Next-state logic: advances timers, handles a button change or runs one
// step of the mode machine for a time step.
// ----------------------------------------------------------------------------
module aess_step import aess_pkg::*; (
  input  cfg_t   cfg,
  input  state_t cur,
  input  item_t  item,
  output state_t nxt
);

  logic [17:0] motion_sum;
  logic [10:0] pause_sum;
  logic [10:0] deb_sum;
  logic [12:0] mag;
  logic        low_reading;
  logic [3:0]  low_inc;
  logic        in_motion;

  // Checks one motion step for its end: target is the end mode to enter; a fault timeout enters MODE_ERROR.
  function automatic state_t drive(input state_t s, input mode_t target, input cfg_t c,
                                   input logic low, input logic [3:0] inc);
    state_t r;
    r = s;
    if (c.end_by_time) begin
      if ({1'b0, r.motion_timer} >= {1'b0, c.travel_time_ms}) begin
        r.mode = target;
      end
    end else if (low) begin
      r.low_readings = inc;
      if (inc > c.low_count_limit) begin
        r.mode = target;
        r.low_readings = 4'd0;
      end
    end else if (r.motion_timer >= c.fault_time_ms) begin
      r.timeout_flag = 1'b1;
      r.mode = MODE_ERROR;
    end
    return r;
  endfunction

  assign in_motion  = (cur.mode == MODE_EXTEND) || (cur.mode == MODE_RETRACT);
  assign motion_sum = {1'b0, cur.motion_timer} + {8'd0, item.elapsed_ms};
  assign pause_sum  = {1'b0, cur.pause_timer} + {1'b0, item.elapsed_ms};
  assign deb_sum    = {1'b0, cur.debounce_timer} + {1'b0, item.elapsed_ms};

  // Magnitude of the signed sample; the most negative code maps to 4096.
  assign mag         = item.current_ma[12] ? (~item.current_ma + 13'd1) : item.current_ma;
  assign low_reading = mag < {1'b0, cfg.min_current_ma};
  assign low_inc     = (cur.low_readings == LOW_MAX) ? LOW_MAX : cur.low_readings + 4'd1;

  always_comb begin
    nxt = cur;
    if (in_motion) begin
      nxt.motion_timer = motion_sum[17] ? MOTION_MAX : motion_sum[16:0];
    end
    if (cur.mode == MODE_PAUSE) begin
      nxt.pause_timer = pause_sum[10] ? TIMER10_MAX : pause_sum[9:0];
    end
    if (cur.debounce_running) begin
      nxt.debounce_timer = deb_sum[10] ? TIMER10_MAX : deb_sum[9:0];
    end

    if (item.req_type) begin
      if (item.button_level) begin
        nxt.debounce_timer   = 10'd0;
        nxt.debounce_running = 1'b1;
      end else if (cur.debounce_running && (nxt.debounce_timer >= cfg.debounce_ms)) begin
        nxt.press_pending = 1'b1;
      end
    end else begin
      // A pending start-up test launches the extend and drives it in this step.
      if ((nxt.mode == MODE_IDLE) && nxt.test_pending) begin
        nxt.mode         = MODE_EXTEND;
        nxt.motion_timer = 17'd0;
      end
      unique case (nxt.mode)
        MODE_EXTEND: begin
          nxt = drive(nxt, MODE_EXTENDED, cfg, low_reading, low_inc);
        end
        MODE_PAUSE: begin
          if (nxt.pause_timer >= cfg.reverse_pause_ms) begin
            nxt.mode         = MODE_RETRACT;
            nxt.motion_timer = 17'd0;
            nxt = drive(nxt, MODE_RETRACTED, cfg, low_reading, low_inc);
          end
        end
        MODE_RETRACT: begin
          nxt = drive(nxt, MODE_RETRACTED, cfg, low_reading, low_inc);
        end
        MODE_EXTENDED: begin
          if (nxt.test_pending) begin
            nxt.test_pending = 1'b0;
            nxt.mode         = MODE_RETRACT;
            nxt.motion_timer = 17'd0;
          end else if (nxt.press_pending) begin
            nxt.press_pending = 1'b0;
            nxt.mode          = MODE_PAUSE;
            nxt.pause_timer   = 10'd0;
          end
        end
        MODE_RETRACTED: begin
          if (nxt.press_pending) begin
            nxt.press_pending = 1'b0;
            nxt.mode          = MODE_EXTEND;
            nxt.motion_timer  = 17'd0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/actuator_end_stop_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_end_stop_sequencer
// Extend/pause/retract sequencer for a linear actuator with time- or
// current-based end detection, button toggling and a start-up test.
// ----------------------------------------------------------------------------
// Each input transfer (a time step or a button change) yields exactly one
// result transfer showing the mode, motor drives, the fully-extended flag, the
// sticky timeout flag and the low-current count after that item. The block
// takes one item per clock while the result side keeps up: an item is
// registered, the whole state update is combinational, and the result sits
// in an output register, loaded from the item once the output side is free;
// throughput is one item per cycle while the result side keeps up. The user
// must write configuration registers through the plain write port only while
// no item is in flight; the block itself does not enforce this.
module actuator_end_stop_sequencer import aess_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [9:0] elapsed_ms, [10] button_level, [23:11] current_ma
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] mode, [3] motor_extend, [4] motor_retract, [5] fully_out,
  // [6] timed_out, [10:7] low_count, [15:11] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t   cfg;
  state_t state;
  state_t state_next;
  item_t  item;
  logic   item_valid;
  logic   advance;

  aess_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  aess_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (item),
    .nxt  (state_next)
  );

  assign advance       = item_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item.req_type     <= s_axis_tuser;
      item.elapsed_ms   <= s_axis_tdata[9:0];
      item.button_level <= s_axis_tdata[10];
      item.current_ma   <= s_axis_tdata[23:11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode             <= MODE_IDLE;
      state.motion_timer     <= '0;
      state.pause_timer      <= '0;
      state.debounce_timer   <= '0;
      state.debounce_running <= 1'b0;
      state.press_pending    <= 1'b0;
      state.low_readings     <= '0;
      state.timeout_flag     <= 1'b0;
      state.test_pending     <= RST_MOTOR_TEST;
    end else if (advance) begin
      state <= state_next;
    end else if (cfg_we && (cfg_idx_t'(cfg_addr) == CFG_MOTOR_TEST)
                 && (state.mode == MODE_IDLE)) begin
      state.test_pending <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {5'd0,
                       state_next.low_readings,
                       state_next.timeout_flag,
                       state_next.mode == MODE_EXTENDED,
                       state_next.mode == MODE_RETRACT,
                       state_next.mode == MODE_EXTEND,
                       state_next.mode};
    end
  end

endmodule
